// File: sv/tea_pkg.sv
// ----------------------------------------------------------------------------
// tea_pkg
// shared types, constants and the round function of the tea block cipher
// ----------------------------------------------------------------------------
`default_nettype none

package tea_pkg;

    localparam int unsigned WORD_W         = 32;
    localparam int unsigned DEFAULT_ROUNDS = 32;
    localparam int unsigned CFG_IDX_W      = 3;

    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

    localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;

    typedef struct packed {
        logic              dir;   // 0 encrypt, 1 decrypt
        logic [WORD_W-1:0] y;     // first half
        logic [WORD_W-1:0] z;     // second half
    } t_block;

    typedef struct packed {
        logic [WORD_W-1:0] w3;
        logic [WORD_W-1:0] w2;
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] w0;
    } t_key;

    // delta times n, wrapped to a word; elaboration only
    function automatic logic [WORD_W-1:0] sum_const(input int unsigned n);
        logic [2*WORD_W-1:0] prod;
        prod = {{WORD_W{1'b0}}, TEA_DELTA} * (2*WORD_W)'(n);
        return prod[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] tea_mix(
        input logic [WORD_W-1:0] v,
        input logic [WORD_W-1:0] s,
        input logic [WORD_W-1:0] kl,
        input logic [WORD_W-1:0] kr
    );
        return ((v << 4) + kl) ^ (v + s) ^ ((v >> 5) + kr);
    endfunction

endpackage

`default_nettype wire

// File: sv/tea_block_cipher_top.sv
// ----------------------------------------------------------------------------
// tea_block_cipher_top
// tea encrypt / decrypt of 64-bit blocks with a chain of half-round cells
// ----------------------------------------------------------------------------
// channel   direction  signals                          beat
// s_axis    in         tvalid tready tdata[63:0] tuser  one block to process
// m_axis    out        tvalid tready tdata[63:0]        one resulting block
// cfg       in         valid ready index[2:0] data[31:0] one key word write
//
// one block is accepted every cycle while the skid entry is empty; each block
// passes through the 2*ROUNDS half-round cells and then the output register.
// the whole cell chain advances together; it holds only when the output
// register and the skid entry behind it are both full.
// reset clears the valid bits of the cells, the output stage and the key.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_block_cipher_top #(
    parameter int unsigned ROUNDS = tea_pkg::DEFAULT_ROUNDS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [63:0]                   i_s_axis_tdata,  // block_low, block_high
    input  wire logic                          i_s_axis_tuser,  // req_type
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [63:0]                        o_m_axis_tdata,  // result_low, result_high
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [tea_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tea_pkg::WORD_W-1:0]    i_cfg_data
);
    import tea_pkg::*;

    localparam int unsigned CELLS = 2 * ROUNDS;

    t_key   r_key;
    logic   en;
    logic   room;
    logic   vld  [CELLS+1];
    t_block blk  [CELLS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_KEY0: r_key.w0 <= i_cfg_data;
                REG_KEY1: r_key.w1 <= i_cfg_data;
                REG_KEY2: r_key.w2 <= i_cfg_data;
                REG_KEY3: r_key.w3 <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign en              = room;
    assign o_s_axis_tready = en;

    assign vld[0]     = i_s_axis_tvalid;
    assign blk[0].dir = i_s_axis_tuser;
    assign blk[0].y   = i_s_axis_tdata[31:0];
    assign blk[0].z   = i_s_axis_tdata[63:32];

    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        tea_cell #(
            .SUM_ENC (sum_const(k / 2 + 1)),
            .SUM_DEC (sum_const(ROUNDS - k / 2)),
            .PHASE   (k % 2 == 1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (vld[k]),
            .i_blk   (blk[k]),
            .i_key   (r_key),
            .o_vld   (vld[k+1]),
            .o_blk   (blk[k+1])
        );
    end

    tea_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (vld[CELLS]),
        .i_data  ({blk[CELLS].z, blk[CELLS].y}),
        .o_room  (room),
        .o_vld   (o_m_axis_tvalid),
        .o_data  (o_m_axis_tdata),
        .i_ready (i_m_axis_tready)
    );

endmodule

`default_nettype wire

// File: sv/tea_cell.sv
// ----------------------------------------------------------------------------
// tea_cell
// one half round: updates one half of the block from the other and hands on
// ----------------------------------------------------------------------------
`default_nettype none

module tea_cell #(
    parameter logic [31:0] SUM_ENC = 32'h0,
    parameter logic [31:0] SUM_DEC = 32'h0,
    parameter bit          PHASE   = 1'b0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire tea_pkg::t_block i_blk,
    input  wire tea_pkg::t_key i_key,
    output logic               o_vld,
    output tea_pkg::t_block    o_blk
);
    import tea_pkg::*;

    logic              upd_y;
    logic [WORD_W-1:0] src;
    logic [WORD_W-1:0] dst;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] kl;
    logic [WORD_W-1:0] kr;
    logic [WORD_W-1:0] f;
    logic [WORD_W-1:0] dst_new;
    logic              r_vld;
    t_block            r_blk;
    t_block            n_blk;

    // encrypt updates y first, decrypt updates z first
    assign upd_y   = PHASE ^ ~i_blk.dir;
    assign src     = upd_y ? i_blk.z : i_blk.y;
    assign dst     = upd_y ? i_blk.y : i_blk.z;
    assign kl      = upd_y ? i_key.w0 : i_key.w2;
    assign kr      = upd_y ? i_key.w1 : i_key.w3;
    assign sum     = i_blk.dir ? SUM_DEC : SUM_ENC;
    assign f       = tea_mix(src, sum, kl, kr);
    assign dst_new = i_blk.dir ? (dst - f) : (dst + f);

    always_comb begin
        n_blk = i_blk;
        if (upd_y) begin
            n_blk.y = dst_new;
        end else begin
            n_blk.z = dst_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_blk <= n_blk;
        end
    end

    assign o_vld = r_vld;
    assign o_blk = r_blk;

endmodule

`default_nettype wire

// File: sv/tea_skid.sv
// ----------------------------------------------------------------------------
// tea_skid
// output register with one skid entry behind the cell chain
// ----------------------------------------------------------------------------
`default_nettype none

module tea_skid (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_vld,
    input  wire logic [63:0] i_data,
    output logic             o_room,
    output logic             o_vld,
    output logic [63:0]      o_data,
    input  wire logic        i_ready
);
    logic        r_out_vld;
    logic [63:0] r_out;
    logic        r_skid_vld;
    logic [63:0] r_skid;
    logic        out_free;

    assign out_free = !r_out_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            // chain is held while the skid entry is full
            if (i_ready) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (out_free) begin
            r_out_vld <= i_vld;
        end else if (i_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (i_ready) begin
                r_out <= r_skid;
            end
        end else if (out_free) begin
            r_out <= i_data;
        end else if (i_vld) begin
            r_skid <= i_data;
        end
    end

    assign o_room = !r_skid_vld;
    assign o_vld  = r_out_vld;
    assign o_data = r_out;

endmodule

`default_nettype wire

// File: test/tea_tb_pkg.sv
// ----------------------------------------------------------------------------
// tea_tb_pkg
// codes shared by the tea cipher stimulus and the result checker
// ----------------------------------------------------------------------------
package tea_tb_pkg;

    typedef enum logic {
        DIR_ENCRYPT = 1'b0,
        DIR_DECRYPT = 1'b1
    } t_direction;

    // first register index past the four key words; writes there are dropped
    localparam logic [tea_pkg::CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd4;

endpackage

// File: test/tea_result_checker.sv
// ----------------------------------------------------------------------------
// tea_result_checker
// watches the key, block and result channels of the tea cipher, computes the
// expected block for every accepted input and compares results in order
// ----------------------------------------------------------------------------
module tea_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // block_low, block_high
    input  logic        i_s_axis_tuser,   // req_type
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [63:0] i_m_axis_tdata,   // result_low, result_high
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_mismatch_count,
    output int          o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import tea_tb_pkg::*;

    localparam logic [31:0] GOLDEN_STEP = 32'h9e37_79b9;
    localparam int          ROUND_COUNT = 32;

    logic [31:0] key_word [4];
    logic [63:0] expected_blocks [$];
    int          mismatch_count = 0;
    int          pending_count = 0;

    assign o_mismatch_count = mismatch_count;
    assign o_pending_count  = pending_count;

    function automatic logic [31:0] round_mix(logic [31:0] v, logic [31:0] sum,
                                              logic [31:0] kl, logic [31:0] kr);
        return ((v << 4) + kl) ^ (v + sum) ^ ((v >> 5) + kr);
    endfunction

    // returns the block packed the way the output tdata carries it
    function automatic logic [63:0] cipher_block(t_direction dir, logic [31:0] hi,
                                                 logic [31:0] lo);
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] sum;
        int          r;
        y = hi;
        z = lo;
        if (dir == DIR_ENCRYPT) begin
            sum = '0;
            for (r = 0; r < ROUND_COUNT; r++) begin
                sum = sum + GOLDEN_STEP;
                y = y + round_mix(z, sum, key_word[0], key_word[1]);
                z = z + round_mix(y, sum, key_word[2], key_word[3]);
            end
        end else begin
            sum = GOLDEN_STEP * ROUND_COUNT;
            for (r = 0; r < ROUND_COUNT; r++) begin
                z = z - round_mix(y, sum, key_word[2], key_word[3]);
                y = y - round_mix(z, sum, key_word[0], key_word[1]);
                sum = sum - GOLDEN_STEP;
            end
        end
        return {z, y};
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        logic [63:0] want;
        if (!i_rst_n) begin
            foreach (key_word[k]) key_word[k] = '0;
            expected_blocks.delete();
            pending_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    tea_pkg::REG_KEY0: key_word[0] = i_cfg_data;
                    tea_pkg::REG_KEY1: key_word[1] = i_cfg_data;
                    tea_pkg::REG_KEY2: key_word[2] = i_cfg_data;
                    tea_pkg::REG_KEY3: key_word[3] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                expected_blocks.push_back(cipher_block(t_direction'(i_s_axis_tuser),
                                                       i_s_axis_tdata[31:0],
                                                       i_s_axis_tdata[63:32]));
                pending_count++;
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_blocks.size() == 0) begin
                    report_mismatch("result beat with nothing pending",
                                    i_m_axis_tdata[31:0], '0);
                end else begin
                    want = expected_blocks.pop_front();
                    pending_count--;
                    if (i_m_axis_tdata[31:0] !== want[31:0])
                        report_mismatch("result_high", i_m_axis_tdata[31:0], want[31:0]);
                    if (i_m_axis_tdata[63:32] !== want[63:32])
                        report_mismatch("result_low", i_m_axis_tdata[63:32], want[63:32]);
                end
            end
        end
    end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives key writes and blocks of both directions into the tea cipher under
// random source and sink stalls; the checker judges every result beat
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tea_tb_pkg::*;

    localparam int BLOCKS_PER_PHASE = 223;
    localparam int PHASE_COUNT      = 6;
    localparam int HOLDOFF_CYCLES   = 300;
    localparam int PIPE_LATENCY     = 2 * tea_pkg::DEFAULT_ROUNDS + 1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int mismatch_count;
    int pending_count;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    bit holdoff_request = 1'b0;

    always #5 i_clk = ~i_clk;

    tea_block_cipher_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    tea_result_checker result_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_axis_tvalid  (s_tvalid),
        .i_s_axis_tready  (s_tready),
        .i_s_axis_tdata   (s_tdata),
        .i_s_axis_tuser   (s_tuser),
        .i_m_axis_tvalid  (m_tvalid),
        .i_m_axis_tready  (m_tready),
        .i_m_axis_tdata   (m_tdata),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    // result sink: random stalls, or one long hold-off when asked
    initial begin
        forever begin
            @(negedge i_clk);
            if (holdoff_request) begin
                m_tready = 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge i_clk);
                holdoff_request = 1'b0;
            end else begin
                m_tready = ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    task automatic write_key_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_key(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                            logic [31:0] w3);
        write_key_reg(tea_pkg::REG_KEY0, w0);
        write_key_reg(tea_pkg::REG_KEY1, w1);
        write_key_reg(tea_pkg::REG_KEY2, w2);
        write_key_reg(tea_pkg::REG_KEY3, w3);
        // a stray write past the key words must leave the key alone
        write_key_reg(REG_UNUSED_FIRST + 3'($urandom_range(3)), $urandom);
    endtask

    // returns just after the edge where the beat was taken
    task automatic send_block(t_direction dir, logic [31:0] hi, logic [31:0] lo);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = dir;
        s_tdata  = {lo, hi};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // stop offering and hold until every block has come back
    task automatic drain_results();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // key still zero after reset
        send_block(DIR_ENCRYPT, '0, '0);
        send_block(DIR_DECRYPT, '0, '0);
        drain_results();

        load_key('1, '1, '1, '1);
        send_block(DIR_ENCRYPT, '1, '1);
        send_block(DIR_DECRYPT, '1, '1);
        send_block(DIR_ENCRYPT, '0, '1);
        send_block(DIR_DECRYPT, '1, '0);
        send_block(DIR_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
        send_block(DIR_DECRYPT, 32'h0000_0001, 32'h8000_0000);
        send_block(DIR_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef);
        send_block(DIR_DECRYPT, 32'h0123_4567, 32'h89ab_cdef);
        drain_results();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                1:       load_key('0, '0, '0, '0);
                2:       load_key('1, '1, '1, '1);
                4:       load_key(32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555,
                                  32'haaaa_aaaa);
                default: load_key($urandom, $urandom, $urandom, $urandom);
            endcase
            // two phases each: sink sparse, source sparse, then full rate
            case (phase / 2)
                0: begin
                    sender_idle_pct   = 27;
                    receiver_idle_pct = 81;
                end
                1: begin
                    sender_idle_pct   = 81;
                    receiver_idle_pct = 27;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
                // long sink hold-off so the pipe fills and backs up the input
                if (n == 60 && (phase == 1 || phase == 4))
                    holdoff_request = 1'b1;
                send_block(t_direction'($urandom_range(1)), pick_word(), pick_word());
            end
            drain_results();
        end

        repeat (PIPE_LATENCY + 5) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("testbench failed");
        $finish;
    end

endmodule

// File: sim.f
sv/tea_pkg.sv
sv/tea_cell.sv
sv/tea_skid.sv
sv/tea_block_cipher_top.sv
test/tea_tb_pkg.sv
test/tea_result_checker.sv
test/testbench.sv
